// File: rtl/core/pairwise_line_intersection_defines.svh
// assertion macros for the pairwise line intersection block
// no dependencies, taken in by the top level with an include
`ifndef PAIRWISE_LINE_INTERSECTION_DEFINES_SVH
`define PAIRWISE_LINE_INTERSECTION_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pli_pkg.sv
// shared types, widths and codes for the pairwise line intersection block
// no dependencies
`timescale 1ns / 1ps

package pli_pkg;

    localparam int COORD_W    = 15;               // endpoint coordinate
    localparam int COEF_W     = 16;               // a = dy, b = -dx
    localparam int CONST_W    = 32;               // c = a*x + b*y
    localparam int DET_W      = 33;               // determinant
    localparam int NUM_W      = 48;               // cramer numerators
    localparam int MAG_W      = NUM_W;            // divider magnitudes
    localparam int POINT_W    = 13;               // point coordinate
    localparam int QUO_W      = POINT_W + 1;      // quotient bits kept
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int LINE_W     = 4 * COORD_W;      // one stored line
    localparam int LINE_IDX_W = 6;                // earlier_line field
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [CONST_W-1:0] t_const;
    typedef logic signed [DET_W-1:0]   t_det;
    typedef logic signed [NUM_W-1:0]   t_num;
    typedef logic        [MAG_W-1:0]   t_mag;

    localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP  = 2'd2;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [POINT_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [POINT_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C1_MUL,
        ST_C1_SUM,
        ST_RD,
        ST_COEF,
        ST_MUL_C2,
        ST_MUL_DET,
        ST_MUL_NX,
        ST_MUL_NY,
        ST_NY_SUM,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_DONE,
        ST_EMIT_PT,
        ST_EMIT_END,
        ST_EMIT_DROP
    } t_state;

endpackage

// File: rtl/core/pli_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pli_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/pairwise_line_intersection.sv
// top level of the pairwise line intersection block
// depends on pli_pkg, pli_ram and pairwise_line_intersection_defines.svh
`timescale 1ns / 1ps
`include "pairwise_line_intersection_defines.svh"

//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_op, i_first_x/y, i_second_x/y
//  out       output     o_out_valid / i_out_stall  o_kind, o_earlier_line, o_point_x/y, o_last
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  a clear item is taken while the sequencer stays idle; a drop waits in its emit state on any output stall
//  an add item visits each stored line in turn; a parallel pair skips the divisions,
//  and every other pair runs the x division and, when x is in range, the y division
//  the work is set by the two shared multipliers and the 14-step restoring divider,
//  one pair at a time, with one read of the line ram per pair
//  reset clears the state machine, line count, output valid and the image limits;
//  the line ram is not cleared, only entries below the count are ever read
//  a stalled output holds the sequencer at its emit state; input stays stalled
//  until the run is closed, but the output register frees the input side at once

module pairwise_line_intersection
    import pli_pkg::*;
#(
    parameter int MAX_LINES = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input items
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_op,
    input  logic signed [COORD_W-1:0] i_first_x,
    input  logic signed [COORD_W-1:0] i_first_y,
    input  logic signed [COORD_W-1:0] i_second_x,
    input  logic signed [COORD_W-1:0] i_second_y,
    // result items
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [KIND_W-1:0]         o_kind,
    output logic [LINE_IDX_W-1:0]     o_earlier_line,
    output logic [POINT_W-1:0]        o_point_x,
    output logic [POINT_W-1:0]        o_point_y,
    output logic                      o_last,
    // register writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [POINT_W-1:0]        i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_LINES);      // ram address
    localparam int CNT_W = $clog2(MAX_LINES + 1);  // line count, holds MAX_LINES

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [POINT_W-1:0] r_img_w;
    logic [POINT_W-1:0] r_img_h;

    // new line: endpoints and its a1, b1, c1
    t_coord r_ax, r_ay, r_bx, r_by;
    t_coef  r_a1, r_b1;
    t_const r_c1;

    // stored line under test: endpoints, a2, b2, c2
    logic [CNT_W-1:0]  r_idx;
    t_coord            r_cx, r_cy;
    t_coef             r_a2, r_b2;
    t_const            r_c2;
    t_det              r_det;
    t_num              r_nx, r_ny;

    // product registers of the two shared multipliers
    t_num   r_p0, r_p1;
    t_coef  mul_a0, mul_a1;
    t_const mul_b0, mul_b1;

    // divider
    logic               r_div_sel;     // 0 working on x, 1 on y
    t_mag               r_rem;
    t_mag               r_dsr;
    logic [QUO_W-1:0]   r_quo;
    logic               r_neg;
    logic [STEP_W-1:0]  r_step;
    logic [POINT_W-1:0] r_px_hold;

    // output register
    logic                  r_o_valid;
    logic [KIND_W-1:0]     r_kind;
    logic [LINE_IDX_W-1:0] r_eline;
    logic [POINT_W-1:0]    r_px_out, r_py_out;
    logic                  r_last;

    // strobes
    logic              in_acc;
    logic              out_free;
    logic              out_load;
    logic [KIND_W-1:0] out_kind;
    logic              mem_rd, mem_wr;
    logic              pair_done;
    logic [LINE_W-1:0] mem_rdata;

    // divider datapath
    t_num               div_num;
    t_mag               div_nmag;
    logic [DET_W-1:0]   det_mag;
    logic               div_ovf;
    logic               div_ge;
    logic [POINT_W-1:0] div_lim;
    logic               div_ok;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_o_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // line ram, one entry per stored line, packed first_x upwards
    // ---------------------------------------------------------------
    pli_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_LINES)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({r_by, r_bx, r_ay, r_ax}),
        .i_rd_en   (mem_rd),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (mem_rdata)
    );

    // ---------------------------------------------------------------
    // sequencer: reads are issued only after the previous pair is done and
    // the single write closes the run, so no two ram accesses ever overlap
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_rd    = 1'b0;
        mem_wr    = 1'b0;
        out_load  = 1'b0;
        out_kind  = KIND_POINT;
        pair_done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_op == OP_ADD)) begin
                    if (r_count == CNT_W'(MAX_LINES)) begin
                        n_state = ST_EMIT_DROP;
                    end else begin
                        n_state = ST_C1_MUL;
                    end
                end
            end
            ST_C1_MUL:  n_state = ST_C1_SUM;
            ST_C1_SUM:  n_state = ST_RD;
            ST_RD: begin
                if (r_idx == r_count) begin
                    n_state = ST_EMIT_END;
                end else begin
                    mem_rd  = 1'b1;
                    n_state = ST_COEF;
                end
            end
            ST_COEF:    n_state = ST_MUL_C2;
            ST_MUL_C2:  n_state = ST_MUL_DET;
            ST_MUL_DET: n_state = ST_MUL_NX;
            ST_MUL_NX:  n_state = ST_MUL_NY;
            ST_MUL_NY:  n_state = ST_NY_SUM;
            ST_NY_SUM: begin
                // parallel pair, nothing to emit
                if (r_det == '0) begin
                    pair_done = 1'b1;
                    n_state   = ST_RD;
                end else begin
                    n_state = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                // quotient too large for any accepted coordinate
                if (div_ovf) begin
                    pair_done = 1'b1;
                    n_state   = ST_RD;
                end else begin
                    n_state = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN: begin
                if (r_step == '0) begin
                    n_state = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE: begin
                if (!div_ok) begin
                    pair_done = 1'b1;
                    n_state   = ST_RD;
                end else if (!r_div_sel) begin
                    n_state = ST_DIV_INIT;
                end else begin
                    n_state = ST_EMIT_PT;
                end
            end
            ST_EMIT_PT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_kind  = KIND_POINT;
                    pair_done = 1'b1;
                    n_state   = ST_RD;
                end
            end
            ST_EMIT_END: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_END;
                    mem_wr   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_EMIT_DROP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_DROP;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // line count and image limits
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_img_w <= IMAGE_WIDTH_RST;
            r_img_h <= IMAGE_HEIGHT_RST;
        end else begin
            if (in_acc && (i_op == OP_CLEAR)) begin
                r_count <= '0;
            end else if (mem_wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // shared multipliers: operands picked by the step, products registered
    // ---------------------------------------------------------------
    always_comb begin
        mul_a0 = '0;
        mul_b0 = '0;
        mul_a1 = '0;
        mul_b1 = '0;
        case (r_state)
            ST_C1_MUL: begin
                // c1 = a1*ax + b1*ay
                mul_a0 = r_a1;  mul_b0 = t_const'(r_ax);
                mul_a1 = r_b1;  mul_b1 = t_const'(r_ay);
            end
            ST_MUL_C2: begin
                // c2 = a2*cx + b2*cy
                mul_a0 = r_a2;  mul_b0 = t_const'(r_cx);
                mul_a1 = r_b2;  mul_b1 = t_const'(r_cy);
            end
            ST_MUL_DET: begin
                // det = a2*b1 - a1*b2
                mul_a0 = r_a2;  mul_b0 = t_const'(r_b1);
                mul_a1 = r_a1;  mul_b1 = t_const'(r_b2);
            end
            ST_MUL_NX: begin
                // nx = b1*c2 - b2*c1
                mul_a0 = r_b1;  mul_b0 = r_c2;
                mul_a1 = r_b2;  mul_b1 = r_c1;
            end
            ST_MUL_NY: begin
                // ny = a2*c1 - a1*c2
                mul_a0 = r_a2;  mul_b0 = r_c1;
                mul_a1 = r_a1;  mul_b1 = r_c2;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // divider: sign and magnitude, 14 restoring steps after a range check
    // ---------------------------------------------------------------
    assign div_num  = r_div_sel ? r_ny : r_nx;
    assign div_nmag = div_num[NUM_W-1] ? t_mag'(-div_num) : t_mag'(div_num);
    assign det_mag  = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
    assign div_ovf  = div_nmag >= MAG_W'({det_mag, {QUO_W{1'b0}}});
    assign div_ge   = r_rem >= r_dsr;
    assign div_lim  = r_div_sel ? r_img_h : r_img_w;
    // a zero quotient is in range whatever the signs
    assign div_ok   = (r_quo == '0) || (!r_neg && (r_quo <= {1'b0, div_lim}));

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_p0 <= mul_a0 * mul_b0;
        r_p1 <= mul_a1 * mul_b1;

        if (in_acc) begin
            r_ax  <= i_first_x;
            r_ay  <= i_first_y;
            r_bx  <= i_second_x;
            r_by  <= i_second_y;
            r_a1  <= t_coef'(i_second_y) - t_coef'(i_first_y);
            r_b1  <= t_coef'(i_first_x) - t_coef'(i_second_x);
            r_idx <= '0;
        end

        if (pair_done) begin
            r_idx <= r_idx + CNT_W'(1);
        end

        case (r_state)
            ST_C1_SUM: begin
                r_c1 <= CONST_W'(r_p0 + r_p1);
            end
            ST_COEF: begin
                r_cx <= t_coord'(mem_rdata[COORD_W-1:0]);
                r_cy <= t_coord'(mem_rdata[2*COORD_W-1:COORD_W]);
                r_a2 <= t_coef'(t_coord'(mem_rdata[4*COORD_W-1:3*COORD_W]))
                      - t_coef'(t_coord'(mem_rdata[2*COORD_W-1:COORD_W]));
                r_b2 <= t_coef'(t_coord'(mem_rdata[COORD_W-1:0]))
                      - t_coef'(t_coord'(mem_rdata[3*COORD_W-1:2*COORD_W]));
            end
            ST_MUL_DET: begin
                r_c2 <= CONST_W'(r_p0 + r_p1);
            end
            ST_MUL_NX: begin
                r_det <= DET_W'(r_p0 - r_p1);
            end
            ST_MUL_NY: begin
                r_nx <= r_p0 - r_p1;
            end
            ST_NY_SUM: begin
                r_ny      <= r_p0 - r_p1;
                r_div_sel <= 1'b0;
            end
            ST_DIV_INIT: begin
                r_rem  <= div_nmag;
                r_dsr  <= MAG_W'({det_mag, {(QUO_W-1){1'b0}}});
                r_quo  <= '0;
                r_neg  <= div_num[NUM_W-1] ^ r_det[DET_W-1];
                r_step <= STEP_W'(QUO_W - 1);
            end
            ST_DIV_RUN: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_dsr;
                end
                r_quo  <= {r_quo[QUO_W-2:0], div_ge};
                r_dsr  <= r_dsr >> 1;
                r_step <= r_step - STEP_W'(1);
            end
            ST_DIV_DONE: begin
                if (div_ok && !r_div_sel) begin
                    r_px_hold <= r_quo[POINT_W-1:0];
                    r_div_sel <= 1'b1;
                end
            end
            default: ;
        endcase

        // result payload, markers carry zero fields
        if (out_load) begin
            r_kind <= out_kind;
            if (out_kind == KIND_POINT) begin
                r_eline  <= LINE_IDX_W'(r_idx);
                r_px_out <= r_px_hold;
                r_py_out <= r_quo[POINT_W-1:0];
                r_last   <= 1'b0;
            end else begin
                r_eline  <= '0;
                r_px_out <= '0;
                r_py_out <= '0;
                r_last   <= 1'b1;
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_kind;
    assign o_earlier_line = r_eline;
    assign o_point_x      = r_px_out;
    assign o_point_y      = r_py_out;
    assign o_last         = r_last;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // closing a run stores exactly one line
    `PLI_ASSERT_NEXT(a_end_stores_line, i_clk, i_rst_n, (r_state == ST_EMIT_END) && out_free, r_count == $past(r_count) + CNT_W'(1), "run closed without storing the line")
    // every read of the ram is below the fill count
    `PLI_ASSERT_NOW(a_read_below_count, i_clk, i_rst_n, r_state == ST_COEF, r_idx < r_count, "line ram read above fill count")
    // the divider never runs on a parallel pair
    `PLI_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_state == ST_DIV_RUN, r_det != '0, "division by a zero determinant")

endmodule

// File: tb/pli_checker.sv
// checker for the pairwise line intersection block: predicts and compares results
// depends on pli_pkg; watches the input, output and register channels of the block
`timescale 1ns / 1ps

module pli_checker
    import pli_pkg::*;
#(
    parameter int MAX_LINES = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_op,
    input  t_coord                 i_first_x,
    input  t_coord                 i_first_y,
    input  t_coord                 i_second_x,
    input  t_coord                 i_second_y,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [LINE_IDX_W-1:0]  i_earlier_line,
    input  logic [POINT_W-1:0]     i_point_x,
    input  logic [POINT_W-1:0]     i_point_y,
    input  logic                   i_last,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [POINT_W-1:0]     i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_points,
    output int                     o_drops
);

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [LINE_IDX_W-1:0] line;
        logic [POINT_W-1:0]    x;
        logic [POINT_W-1:0]    y;
        logic                  last;
    } t_crossing;

    t_coord             seg_end [MAX_LINES][4];
    int                 lines_held = 0;
    logic [POINT_W-1:0] lim_x = IMAGE_WIDTH_RST;
    logic [POINT_W-1:0] lim_y = IMAGE_HEIGHT_RST;
    t_crossing          crossings_due [$];

    function automatic t_crossing marker(input logic [KIND_W-1:0] k);
        t_crossing c;
        c      = '0;
        c.kind = k;
        c.last = 1'b1;
        return c;
    endfunction

    // append one predicted result at the tail of the queue
    task automatic book_result(input t_crossing c);
        crossings_due.insert(crossings_due.size(), c);
    endtask

    task automatic note_mismatch(input string what, input t_crossing want, input t_crossing got);
        if (o_errors < 10)
            $display("%0t %s: expected kind %0d line %0d x %0d y %0d last %0d, got kind %0d line %0d x %0d y %0d last %0d",
                     $realtime, what, want.kind, want.line, want.x, want.y, want.last,
                     got.kind, got.line, got.x, got.y, got.last);
        o_errors++;
    endtask

    // cramer's rule against every held line, oldest first, then store and close the run
    task automatic intersect_new_line(input t_coord fx, input t_coord fy,
                                      input t_coord sx, input t_coord sy);
        longint    ax, ay, bx, by, a1, b1, c1;
        longint    cx, cy, dx, dy, a2, b2, c2, det, px, py, w, h;
        int        i;
        t_crossing c;
        ax = fx;
        ay = fy;
        bx = sx;
        by = sy;
        w  = lim_x;
        h  = lim_y;
        a1 = by - ay;
        b1 = ax - bx;
        c1 = a1 * ax + b1 * ay;
        for (i = 0; i < lines_held; i++) begin
            cx  = seg_end[i][0];
            cy  = seg_end[i][1];
            dx  = seg_end[i][2];
            dy  = seg_end[i][3];
            a2  = dy - cy;
            b2  = cx - dx;
            c2  = a2 * cx + b2 * cy;
            det = a2 * b1 - a1 * b2;
            if (det != 0) begin
                // division truncates toward zero
                px = (b1 * c2 - b2 * c1) / det;
                py = (a2 * c1 - a1 * c2) / det;
                if (px >= 0 && px <= w && py >= 0 && py <= h) begin
                    c      = '0;
                    c.kind = KIND_POINT;
                    c.line = i[LINE_IDX_W-1:0];
                    c.x    = px[POINT_W-1:0];
                    c.y    = py[POINT_W-1:0];
                    book_result(c);
                end
            end
        end
        seg_end[lines_held][0] = fx;
        seg_end[lines_held][1] = fy;
        seg_end[lines_held][2] = sx;
        seg_end[lines_held][3] = sy;
        lines_held++;
        book_result(marker(KIND_END));
    endtask

    always @(posedge i_clk) begin : watch
        t_crossing got, want;
        if (!i_rst_n) begin
            lines_held = 0;
            lim_x      = IMAGE_WIDTH_RST;
            lim_y      = IMAGE_HEIGHT_RST;
            o_errors   = 0;
            o_points   = 0;
            o_drops    = 0;
            crossings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH)
                    lim_x = i_cfg_data;
                else if (i_cfg_index == CFG_IMAGE_HEIGHT)
                    lim_y = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_op == OP_CLEAR)
                    lines_held = 0;
                else if (lines_held >= MAX_LINES)
                    book_result(marker(KIND_DROP));
                else
                    intersect_new_line(i_first_x, i_first_y, i_second_x, i_second_y);
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_kind, i_earlier_line, i_point_x, i_point_y, i_last};
                if (crossings_due.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = crossings_due.pop_front();
                    if (got !== want)
                        note_mismatch("result mismatch", want, got);
                    else if (want.kind == KIND_POINT)
                        o_points++;
                    else if (want.kind == KIND_DROP)
                        o_drops++;
                end
            end
        end
        o_pending = crossings_due.size();
    end

endmodule

// File: tb/tb_pairwise_line_intersection.sv
// testbench top for the pairwise line intersection block: stimulus, idling and verdict
// depends on pli_pkg, the block itself and pli_checker, which predicts and compares
`timescale 1ns / 1ps

module tb_pairwise_line_intersection;
    import pli_pkg::*;

    localparam int MAX_LINES     = 32;
    localparam int HOLD_CYCLES   = 400;  // long receiver hold-off, fills the block up
    localparam int SETTLE_CYCLES = 8;    // gives a trailing clear time to take effect
    localparam int DRAIN_CYCLES  = 200;  // quiet spell at the end to catch stray results

    // every block input starts at a known value
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_op        = OP_ADD;
    t_coord                i_first_x   = '0;
    t_coord                i_first_y   = '0;
    t_coord                i_second_x  = '0;
    t_coord                i_second_y  = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_IMAGE_WIDTH;
    logic [POINT_W-1:0]    i_cfg_data  = IMAGE_WIDTH_RST;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [KIND_W-1:0]     o_kind;
    logic [LINE_IDX_W-1:0] o_earlier_line;
    logic [POINT_W-1:0]    o_point_x;
    logic [POINT_W-1:0]    o_point_y;
    logic                  o_last;
    logic                  o_cfg_ready;

    int errors, pending, points, drops;

    // idling percentages per phase, and the long hold-off request
    int send_idle_pct = 18;
    int recv_idle_pct = 45;
    int hold_req      = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    // image limits as last written, used to aim random lines into the frame
    int cur_w       = 640;
    int cur_h       = 480;
    int items_sent  = 0;
    int cfg_writes  = 0;

    pairwise_line_intersection #(
        .MAX_LINES(MAX_LINES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_first_x      (i_first_x),
        .i_first_y      (i_first_y),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_earlier_line (o_earlier_line),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    pli_checker #(
        .MAX_LINES(MAX_LINES)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_first_x      (i_first_x),
        .i_first_y      (i_first_y),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_kind         (o_kind),
        .i_earlier_line (o_earlier_line),
        .i_point_x      (o_point_x),
        .i_point_y      (o_point_y),
        .i_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_points       (points),
        .o_drops        (drops)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // slowest honest run: ~200 items, each with the sequencer's work and up to 33 results
    // waiting out receiver stalls, plus one long hold-off - well under 5 ms, so 20 ms
    initial begin
        #20_000_000;
        $display("run timed out with %0d results still awaited", pending);
        $display("tb: failure");
        $finish;
    end

    // receiver side: random stall, or a long counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_taken != hold_req) begin
            hold_taken  <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // one input transfer; valid is held until accepted and the payload stays put
    task automatic push_item(input logic op, input int fx, input int fy,
                             input int sx, input int sy);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_first_x  <= fx[COORD_W-1:0];
        i_first_y  <= fy[COORD_W-1:0];
        i_second_x <= sx[COORD_W-1:0];
        i_second_y <= sy[COORD_W-1:0];
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic add_line(input int fx, input int fy, input int sx, input int sy);
        push_item(OP_ADD, fx, fy, sx, sy);
    endtask

    // drop valid and let every awaited result come home; sampled at the falling
    // edge so the checker has already booked the last transfer
    task automatic wait_idle;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both image limits, back to back with valid held high; only called when idle
    task automatic set_limits(input int w, input int h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= w[POINT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= h[POINT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_w       = w;
        cur_h       = h;
        cfg_writes += 2;
    endtask

    // mostly inside the frame with a small margin, sometimes anywhere, now and then extremes
    function automatic int rand_coord(input int lim);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return $urandom_range(0, lim + 64) - 32;
        else if (pick < 18)
            return int'($urandom_range(0, 32767)) - 16384;
        else if (pick == 18)
            return -16384;
        else
            return 16383;
    endfunction

    // random add, with flat, upright and single-point lines mixed in, or a clear
    task automatic random_item(input int clear_pct);
        int fx, fy, sx, sy;
        fx = rand_coord(cur_w);
        fy = rand_coord(cur_h);
        sx = rand_coord(cur_w);
        sy = rand_coord(cur_h);
        if ($urandom_range(0, 99) < clear_pct) begin
            push_item(OP_CLEAR, fx, fy, sx, sy);
        end else begin
            case ($urandom_range(0, 11))
                0: sy = fy;
                1: sx = fx;
                2: begin
                    sx = fx;
                    sy = fy;
                end
                default: ;
            endcase
            add_line(fx, fy, sx, sy);
        end
    endtask

    initial begin
        int k;

        // synchronous reset, once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- phase one: sender idles 18 %, receiver 45 % ----

        // directed, reset limits 640 x 480
        push_item(OP_CLEAR, -1, 16383, -16384, 0);       // clear on an empty store
        add_line(0, 100, 640, 100);                      // first line, end marker only
        add_line(200, 0, 200, 480);                      // crosses at (200,100)
        add_line(0, 300, 640, 300);                      // parallel to line 0, skipped
        add_line(50, 50, 50, 50);                        // single point, no crossings
        add_line(-16384, -16384, 16383, 16383);          // extreme diagonal
        add_line(16383, -16384, -16384, 16383);          // crossings fall below zero
        add_line(640, 0, 640, 480);                      // right-hand edge exactly
        add_line(641, 0, 641, 480);                      // one column past the edge
        add_line(0, 480, 640, 0);                        // fractional crossings
        add_line(3, 7, -5, -2);
        add_line(-7, 1, 2, -9);
        wait_idle();

        // widest limits
        set_limits(8191, 8191);
        add_line(8191, 0, 8191, 8191);
        add_line(0, 8191, 8191, 8191);                   // corner at the far limit
        add_line(-3, 16383, 5, -16384);                  // steep, spans the full range
        wait_idle();

        // narrowest limits, including a crossing at x = -0.5 that truncates to zero
        set_limits(1, 1);
        add_line(0, 0, 1, 1);
        add_line(1, -1, -1, 1);
        push_item(OP_CLEAR, 16383, -16384, 16383, -16384);
        add_line(0, 1, 2, 0);
        add_line(0, 0, 3, 1);
        add_line(0, 1, 5, 1);
        add_line(-1, 0, 0, 2);
        wait_idle();

        // fill the store past its size while the receiver holds off for a long spell,
        // so the output backs up and the input stalls; the tail gets dropped lines
        set_limits(640, 480);
        push_item(OP_CLEAR, 0, 0, 0, 0);
        hold_req <= hold_req + 1;
        for (k = 0; k < MAX_LINES + 4; k++)
            random_item(0);
        for (k = 0; k < 14; k++)
            random_item(5);
        wait_idle();

        // ---- phase two: sender idles 45 %, receiver 18 % ----
        send_idle_pct = 45;
        recv_idle_pct = 18;
        set_limits($urandom_range(200, 4000), $urandom_range(200, 4000));
        for (k = 0; k < 25; k++)
            random_item(4);
        wait_idle();                                     // pause until all results are in
        for (k = 0; k < 25; k++)
            random_item(4);
        wait_idle();

        // ---- phase three: no idling on either side ----
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(8191, $urandom_range(1, 8191));
        for (k = 0; k < 30; k++)
            random_item(3);

        // drain, then a quiet spell for anything stray
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input transfers and %0d register writes over three idling phases",
                 items_sent, cfg_writes);
        $display("checked %0d intersection points and %0d full-store drops, %0d mismatches",
                 points, drops, errors);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
